FILE: src/eba_pkg.sv
// ----------------------------------------------------------------------------
// eba_pkg
// shared types, operation codes and constants of the accumulator alu
// ----------------------------------------------------------------------------
package eba_pkg;

  localparam int DataWidth = 8;
  localparam int FuncWidth = 3;
  localparam int SignBit   = DataWidth - 1;  // index of the msb, bit 7

  // operation codes, codes five to seven are ignored
  localparam logic [FuncWidth-1:0] FUNC_ADC = 3'd0;
  localparam logic [FuncWidth-1:0] FUNC_SBC = 3'd1;
  localparam logic [FuncWidth-1:0] FUNC_AND = 3'd2;
  localparam logic [FuncWidth-1:0] FUNC_ASL = 3'd3;
  localparam logic [FuncWidth-1:0] FUNC_CMP = 3'd4;

  // accumulator and flags
  typedef struct packed {
    logic [DataWidth-1:0] acc;
    logic                 c;
    logic                 z;
    logic                 n;
    logic                 v;
  } eba_state_t;

endpackage

FILE: src/eba_if.sv
// ----------------------------------------------------------------------------
// eba_in_if / eba_out_if
// valid/ready channels for operation requests and alu results
// ----------------------------------------------------------------------------
interface eba_in_if import eba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FuncWidth-1:0] func;
  logic [DataWidth-1:0] operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink   (input valid, input func, input operand, output ready);
endinterface

interface eba_out_if import eba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] acc_out;
  logic                 carry_flag;
  logic                 zero_flag;
  logic                 negative_flag;
  logic                 overflow_flag;

  modport source (output valid, output acc_out, output carry_flag, output zero_flag,
                  output negative_flag, output overflow_flag, input ready);
  modport sink   (input valid, input acc_out, input carry_flag, input zero_flag,
                  input negative_flag, input overflow_flag, output ready);
endinterface

FILE: src/eba_alu.sv
// ----------------------------------------------------------------------------
// eba_alu
// combinational datapath: next accumulator and flags from one operation
// ----------------------------------------------------------------------------
module eba_alu import eba_pkg::*; (
  input  eba_state_t           cur,
  input  logic [FuncWidth-1:0] func,
  input  logic [DataWidth-1:0] operand,
  output eba_state_t           nxt
);

  logic [DataWidth-1:0] addend;
  logic                 cin;
  logic [DataWidth:0]   sum;
  logic [DataWidth-1:0] res;

  // one shared adder: add, subtract (inverted operand) and compare (carry in one)
  always_comb begin
    addend = (func == FUNC_ADC) ? operand : ~operand;
    cin    = (func == FUNC_CMP) ? 1'b1 : cur.c;
    sum    = {1'b0, cur.acc} + {1'b0, addend} + {{DataWidth{1'b0}}, cin};
    res    = sum[DataWidth-1:0];
  end

  always_comb begin
    nxt = cur;
    unique case (func)
      FUNC_ADC, FUNC_SBC: begin
        nxt.acc = res;
        nxt.c   = sum[DataWidth];
        nxt.v   = ~(cur.acc[SignBit] ^ addend[SignBit]) & (cur.acc[SignBit] ^ res[SignBit]);
        nxt.z   = (res == '0);
        nxt.n   = res[SignBit];
      end
      FUNC_AND: begin
        nxt.acc = cur.acc & operand;
        nxt.z   = ((cur.acc & operand) == '0);
        nxt.n   = cur.acc[SignBit] & operand[SignBit];
      end
      FUNC_ASL: begin
        nxt.acc = {operand[DataWidth-2:0], 1'b0};
        nxt.c   = operand[SignBit];
        nxt.z   = (operand[DataWidth-2:0] == '0);
        nxt.n   = operand[SignBit-1];
      end
      FUNC_CMP: begin
        // no borrow out of acc - operand means acc >= operand
        nxt.c = sum[DataWidth];
        nxt.z = (res == '0);
        nxt.n = res[SignBit];
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: src/eight_bit_accumulator_alu.sv
// ----------------------------------------------------------------------------
// eight_bit_accumulator_alu
// accumulator alu with carry, zero, negative and overflow flags
// ----------------------------------------------------------------------------
// an accepted operation passes through the input register, then the
//   accumulator/flag register that drives the result; a blocked output
//   holds it in the input register
// throughput: one operation per cycle while results are taken, set by the
//   single adder feeding back into the accumulator and carry registers
// reset: synchronous active-low rst_n clears accumulator, flags and valids
// ----------------------------------------------------------------------------
module eight_bit_accumulator_alu import eba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  eba_in_if.sink    in_ch,
  eba_out_if.source out_ch
);

  // input register stage
  logic                 s1_valid_r;
  logic [FuncWidth-1:0] s1_func_r;
  logic [DataWidth-1:0] s1_operand_r;

  // architectural state, which is also the result register
  eba_state_t state_r;
  eba_state_t state_nxt;
  logic       out_valid_r;

  logic s1_advance;
  logic in_xfer;

  // the result slot frees when empty or when its transfer completes
  assign s1_advance   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload of the input register needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r    <= in_ch.func;
      s1_operand_r <= in_ch.operand;
    end
  end

  eba_alu u_alu (
    .cur     (state_r),
    .func    (s1_func_r),
    .operand (s1_operand_r),
    .nxt     (state_nxt)
  );

  // state moves only when a result is handed to the output slot, so the
  // reported values always match the accumulator and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_advance) begin
        state_r <= state_nxt;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.acc_out       = state_r.acc;
  assign out_ch.carry_flag    = state_r.c;
  assign out_ch.zero_flag     = state_r.z;
  assign out_ch.negative_flag = state_r.n;
  assign out_ch.overflow_flag = state_r.v;

  // compare never writes the accumulator
  a_cmp_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && (s1_func_r == FUNC_CMP) |=> $stable(state_r.acc))
    else $error("compare changed the accumulator");

  // only add and subtract touch overflow
  a_ovf_only_arith: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && (s1_func_r != FUNC_ADC) && (s1_func_r != FUNC_SBC) |=> $stable(state_r.v))
    else $error("overflow changed by a non-arithmetic operation");

  // input stalls only when both stages hold an item and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a blocked pipeline");

  // a result appears only from an item in the input stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a pending operation");

  // state changes only when an item leaves the input stage
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_advance |=> $stable(state_r))
    else $error("state changed without an operation");

endmodule

FILE: bench/eight_bit_accumulator_alu_tb.sv
// ----------------------------------------------------------------------------
// eight_bit_accumulator_alu_tb
// self-checking bench for the accumulator alu: a short table of directed
// operations, some with hand-worked results, then about eight hundred random
// operations checked against a cycle-free model of accumulator and flags,
// under three mixes of sender and receiver idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module eight_bit_accumulator_alu_tb;
  import eba_pkg::*;

  // codes five to seven carry no operation, the alu only reports its state
  localparam logic [FuncWidth-1:0] FUNC_RSV5 = 3'd5;
  localparam logic [FuncWidth-1:0] FUNC_RSV6 = 3'd6;
  localparam logic [FuncWidth-1:0] FUNC_RSV7 = 3'd7;

  localparam int DirRows       = 25;
  localparam int WatchdogLimit = 2000;  // cycles with no transfer on either side
  localparam int HoldOffCycles = 80;    // long receiver stall, fills the pipeline
  localparam int DrainCycles   = 8;     // idle margin after the last result is back

  // one row of the directed table; golden is used only where has_golden is set
  typedef struct packed {
    logic [FuncWidth-1:0] func;
    logic [DataWidth-1:0] operand;
    logic                 has_golden;
    eba_state_t           golden;
  } dir_row_t;

  logic clk;
  logic rst_n;

  eba_in_if  in_ch ();
  eba_out_if out_ch ();

  eight_bit_accumulator_alu u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model copy of accumulator and flags, advanced at every input transfer
  eba_state_t acc_model = '0;
  // accumulator and flags that the alu should report, oldest first
  eba_state_t expected_states [$];

  // golden value that goes with the item currently offered
  logic       pending_golden_valid = 1'b0;
  eba_state_t pending_golden       = '0;

  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  int hold_off_requests = 0;
  int err_count         = 0;
  int results_checked   = 0;
  int op_count [8];
  int idle_cycles       = 0;

  dir_row_t directed_rows [DirRows];

  // --------------------------------------------------------------------------
  // clock, 4 ns period
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // next accumulator and flags for one operation
  // --------------------------------------------------------------------------
  function automatic eba_state_t alu_exec(input eba_state_t cur,
                                          input logic [FuncWidth-1:0] f,
                                          input logic [DataWidth-1:0] m);
    eba_state_t           nxt;
    logic [DataWidth-1:0] addend;
    logic [DataWidth:0]   sum;
    logic [DataWidth-1:0] diff;
    nxt = cur;
    case (f)
      FUNC_ADC, FUNC_SBC: begin
        // subtract is add of the inverted operand, carry set means no borrow
        addend = (f == FUNC_SBC) ? ~m : m;
        sum    = {1'b0, cur.acc} + {1'b0, addend} + {{DataWidth{1'b0}}, cur.c};
        nxt.acc = sum[DataWidth-1:0];
        nxt.c   = sum[DataWidth];
        // signed overflow: same-sign inputs, result sign flipped
        nxt.v   = (cur.acc[SignBit] == addend[SignBit]) &&
                  (sum[SignBit] != cur.acc[SignBit]);
        nxt.z   = (sum[DataWidth-1:0] == '0);
        nxt.n   = sum[SignBit];
      end
      FUNC_AND: begin
        nxt.acc = cur.acc & m;
        nxt.z   = (nxt.acc == '0);
        nxt.n   = nxt.acc[SignBit];
      end
      FUNC_ASL: begin
        // shifts the operand byte, not the accumulator
        nxt.c   = m[SignBit];
        nxt.acc = {m[DataWidth-2:0], 1'b0};
        nxt.z   = (nxt.acc == '0);
        nxt.n   = nxt.acc[SignBit];
      end
      FUNC_CMP: begin
        // flags only, accumulator and overflow untouched
        diff  = cur.acc - m;
        nxt.c = (cur.acc >= m);
        nxt.z = (cur.acc == m);
        nxt.n = diff[SignBit];
      end
      default: ;
    endcase
    return nxt;
  endfunction

  function automatic dir_row_t mk_row(input logic [FuncWidth-1:0] f,
                                      input logic [DataWidth-1:0] m,
                                      input logic chk,
                                      input logic [DataWidth-1:0] a,
                                      input logic [3:0] cznv);
    dir_row_t r;
    r.func       = f;
    r.operand    = m;
    r.has_golden = chk;
    r.golden     = {a, cznv};
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DataWidth-1:0] want,
                             input logic [DataWidth-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // monitor: checks output transfers, then predicts from input transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    eba_state_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_states.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected, actual acc %0h flags czn v %b%b%b %b",
                   $time, out_ch.acc_out, out_ch.carry_flag, out_ch.zero_flag,
                   out_ch.negative_flag, out_ch.overflow_flag);
        end else begin
          want = expected_states.pop_front();
          check_field("acc_out", want.acc, out_ch.acc_out);
          check_field("carry_flag", {7'd0, want.c}, {7'd0, out_ch.carry_flag});
          check_field("zero_flag", {7'd0, want.z}, {7'd0, out_ch.zero_flag});
          check_field("negative_flag", {7'd0, want.n}, {7'd0, out_ch.negative_flag});
          check_field("overflow_flag", {7'd0, want.v}, {7'd0, out_ch.overflow_flag});
          results_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        // model always advances; hand-worked rows replace its value in the queue
        acc_model = alu_exec(acc_model, in_ch.func, in_ch.operand);
        expected_states.push_back(pending_golden_valid ? pending_golden : acc_model);
        op_count[in_ch.func]++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transfer ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, expected_states.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random ready, plus a long hold-off when the stimulus asks
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_requests > hold_served) begin
        hold_served++;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender: offer one operation from a falling edge until its transfer;
  // valid stays high into the next item unless an idle cycle is drawn
  // --------------------------------------------------------------------------
  task automatic send_op(input logic [FuncWidth-1:0] f, input logic [DataWidth-1:0] m,
                         input logic chk, input eba_state_t gold);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.operand <= m;
    pending_golden_valid = chk;
    pending_golden       = gold;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // drop valid and hold the sender until every result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_states.size() != 0);
  endtask

  // random operations, ignored codes mixed in but not counted
  task automatic run_random(input int n_ops, input bit with_hold_off);
    int                   done;
    int                   pick;
    logic [FuncWidth-1:0] f;
    logic [DataWidth-1:0] m;
    done = 0;
    while (done < n_ops) begin
      if ($urandom_range(99) < 6) begin
        f = FUNC_RSV5 + FuncWidth'($urandom_range(2));
      end else begin
        f = FuncWidth'($urandom_range(FUNC_CMP, FUNC_ADC));
        done++;
      end
      // lean on the corners: zero, all ones, sign boundary, and the current
      // accumulator so compare and subtract hit equality often
      pick = $urandom_range(9);
      case (pick)
        0:       m = '0;
        1:       m = '1;
        2:       m = 8'h80;
        3:       m = 8'h7f;
        4:       m = acc_model.acc;
        default: m = DataWidth'($urandom_range(255));
      endcase
      // long receiver stall while the sender keeps offering
      if (with_hold_off && done == n_ops / 3) hold_off_requests++;
      send_op(f, m, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_ADC;
    in_ch.operand <= '0;
    rst_n         <= 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, golden values worked by hand from reset state
    directed_rows = '{
      mk_row(FUNC_RSV5, 8'hff, 1'b1, 8'h00, 4'b0000),  // ignored code reports reset
      mk_row(FUNC_ADC,  8'h00, 1'b1, 8'h00, 4'b0100),
      mk_row(FUNC_ADC,  8'hff, 1'b1, 8'hff, 4'b0010),
      mk_row(FUNC_ADC,  8'h01, 1'b1, 8'h00, 4'b1100),  // carry out, wrap to zero
      mk_row(FUNC_ADC,  8'h7f, 1'b1, 8'h80, 4'b0011),  // carry in, positive overflow
      mk_row(FUNC_ADC,  8'h80, 1'b1, 8'h00, 4'b1101),  // negative overflow
      mk_row(FUNC_RSV7, 8'h00, 1'b1, 8'h00, 4'b1101),  // state held
      mk_row(FUNC_SBC,  8'h00, 1'b1, 8'h00, 4'b1100),  // no borrow, overflow cleared
      mk_row(FUNC_SBC,  8'h01, 1'b1, 8'hff, 4'b0010),  // borrow
      mk_row(FUNC_SBC,  8'h7f, 1'b1, 8'h7f, 4'b1001),  // borrow in, overflow
      mk_row(FUNC_SBC,  8'hff, 1'b1, 8'h80, 4'b0011),
      mk_row(FUNC_AND,  8'hff, 1'b1, 8'h80, 4'b0011),  // carry and overflow kept
      mk_row(FUNC_AND,  8'h7f, 1'b1, 8'h00, 4'b0101),
      mk_row(FUNC_ASL,  8'hff, 1'b1, 8'hfe, 4'b1011),
      mk_row(FUNC_ASL,  8'h80, 1'b1, 8'h00, 4'b1101),
      mk_row(FUNC_ASL,  8'h40, 1'b1, 8'h80, 4'b0011),
      mk_row(FUNC_ASL,  8'h00, 1'b1, 8'h00, 4'b0101),
      mk_row(FUNC_CMP,  8'h00, 1'b1, 8'h00, 4'b1101),  // equal
      mk_row(FUNC_CMP,  8'h01, 1'b1, 8'h00, 4'b0011),  // less, difference negative
      mk_row(FUNC_ADC,  8'hff, 1'b1, 8'hff, 4'b0010),
      mk_row(FUNC_CMP,  8'hff, 1'b1, 8'hff, 4'b1100),
      mk_row(FUNC_CMP,  8'h80, 1'b0, 8'h00, 4'b0000),
      mk_row(FUNC_RSV6, 8'ha5, 1'b0, 8'h00, 4'b0000),
      mk_row(FUNC_SBC,  8'h55, 1'b0, 8'h00, 4'b0000),
      mk_row(FUNC_ADC,  8'haa, 1'b0, 8'h00, 4'b0000)
    };

    // phase one: sender mostly busy, receiver often stalled
    send_idle_pct = 9;
    recv_idle_pct = 59;
    foreach (directed_rows[i]) begin
      send_op(directed_rows[i].func, directed_rows[i].operand,
              directed_rows[i].has_golden, directed_rows[i].golden);
    end
    run_random(300, 1'b1);
    drain_results();

    // phase two: sender sparse, receiver mostly ready
    send_idle_pct = 59;
    recv_idle_pct = 9;
    run_random(250, 1'b0);
    drain_results();

    // phase three: back to back, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250, 1'b0);
    drain_results();

    repeat (DrainCycles) @(negedge clk);

    $display("checked %0d results: adc %0d, sbc %0d, and %0d, asl %0d, cmp %0d",
             results_checked, op_count[FUNC_ADC], op_count[FUNC_SBC],
             op_count[FUNC_AND], op_count[FUNC_ASL], op_count[FUNC_CMP]);
    $display("ignored codes %0d, three idling mixes, one long receiver hold-off",
             op_count[FUNC_RSV5] + op_count[FUNC_RSV6] + op_count[FUNC_RSV7]);
    if (err_count == 0 && expected_states.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: eight_bit_accumulator_alu.f
src/eba_pkg.sv
src/eba_if.sv
src/eba_alu.sv
src/eight_bit_accumulator_alu.sv
bench/eight_bit_accumulator_alu_tb.sv
